FILE: sv/point_in_tetrahedron_test_core_defines.svh
// Assertion helpers shared by the checker.
`ifndef POINT_IN_TETRAHEDRON_TEST_CORE_DEFINES_SVH
`define POINT_IN_TETRAHEDRON_TEST_CORE_DEFINES_SVH

// check while out of reset
`define PITT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check on every edge, reset included
`define PITT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/pitt_pkg.sv
package pitt_pkg;

  localparam int COORD_W  = 16;
  localparam int FRAC_W   = 8;   // determinant unit is 2^-(3*FRAC_W)
  localparam int TOL_W    = 53;
  localparam int VOL_W    = 52;
  localparam int DET_W    = 64;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int PROD_W   = 2 * DIFF_W;
  localparam int COF_W    = PROD_W + 1;
  localparam int TERM_W   = DIFF_W + COF_W;
  localparam int NUM_VERT = 4;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(16777);
  localparam logic [VOL_W-1:0] VOL_MAX   = {VOL_W{1'b1}};

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic       func;
    logic [1:0] vertex_index;
    coord_t     x;
    coord_t     y;
    coord_t     z;
  } in_item_t;

  typedef struct packed {
    logic             inside_res;
    logic             inside_or_on;
    logic [VOL_W-1:0] volume;
  } out_item_t;

  typedef struct packed {
    logic       is_query;
    logic [1:0] vidx;
    coord_t     x;
    coord_t     y;
    coord_t     z;
  } q_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIFF, ST_MUL1, ST_MUL2, ST_SUM, ST_PREP, ST_DIV, ST_OUT
  } bk_state_t;

endpackage

FILE: sv/point_in_tetrahedron_test_core.sv
// Point-in-tetrahedron test.
// Input channel in_valid/in_ready/in_data: func load writes one vertex of the
// four-entry store, func query tests a point against the stored tetrahedron.
// Result channel out_valid/out_ready/out_data: one item per input item with a
// strict inside flag, an inside-or-on flag (tolerance widened) and the volume
// |D0|/6 in 2^-24 units. Loads give both flags zero.
// cfg_we/cfg_wdata write the determinant tolerance at any edge with cfg_we.
// A two-entry queue sits in front of the determinant engine, so up to two
// items wait there while the engine or the receiver is busy.
// After an item leaves the queue, a query's result is offered once five
// determinants (difference, two multiply and sum states each, on one shared
// multiplier bank), a setup state and eight divide-by-three steps are done;
// a load has one determinant in place of five. An item can leave the queue
// at the earliest in the cycle after it is accepted. The engine takes no new
// item until the last result is taken and it is back in its idle state.
// Reset clears the vertex store to zero, the tolerance to 16777 and the queue.
// A stalled receiver holds the result; the queue then fills and in_ready drops.
module point_in_tetrahedron_test_core import pitt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_wdata
);

  logic [TOL_W-1:0] tol_r;
  logic             q_valid, q_pop;
  q_item_t          q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  pitt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  pitt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .tolerance (tol_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: sv/pitt_front.sv
module pitt_front import pitt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_valid,
  output q_item_t  q_item,
  input  logic     q_pop
);

  q_item_t    ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;
  q_item_t    cls;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = ent_r[rp_r];

  always_comb begin
    cls.is_query = (in_data.func == FUNC_QUERY);
    cls.vidx     = in_data.vertex_index;
    cls.x        = in_data.x;
    cls.y        = in_data.y;
    cls.z        = in_data.z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      if (push && !q_pop) cnt_r <= cnt_r + 2'd1;
      else if (!push && q_pop) cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= cls;
  end

endmodule

FILE: sv/pitt_back.sv
module pitt_back import pitt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  q_item_t          q_item,
  output logic             q_pop,
  input  logic [TOL_W-1:0] tolerance,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  bk_state_t state_r, state_nxt;
  q_item_t   cur_r;
  coord_t    vs_r [NUM_VERT][3];
  logic [2:0] k_r;
  logic [2:0] dcnt_r;

  logic signed [DIFF_W-1:0] u_r [3], v_r [3], w_r [3];
  logic signed [PROD_W-1:0] pr_r [6];
  logic signed [TERM_W-1:0] t_r [3];
  logic signed [DET_W-1:0]  d0_r;
  logic strict_r, loose_r;

  logic [DET_W-1:0] dvd_r, q_r;
  logic [1:0]       rem_r;

  coord_t vsel [NUM_VERT][3];
  coord_t pt [3];
  logic signed [DIFF_W-1:0] u_c [3], v_c [3], w_c [3];
  logic signed [COF_W-1:0]  cof [3];
  logic signed [DET_W+1:0]  sum_w;
  logic signed [DET_W-1:0]  det;
  logic signed [DET_W-1:0]  tol_s;
  logic [DET_W-1:0]         det_mag, d0_mag;
  logic [9:0]               dv;
  logic [19:0]              dprod;
  logic [7:0]               q8;
  logic [1:0]               r2;

  function automatic logic [DET_W-1:0] mag(input logic signed [DET_W-1:0] s);
    mag = s[DET_W-1] ? DET_W'(-s) : DET_W'(s);
  endfunction

  always_comb begin
    pt[0] = cur_r.x;
    pt[1] = cur_r.y;
    pt[2] = cur_r.z;
    for (int j = 0; j < NUM_VERT; j++) begin
      for (int c = 0; c < 3; c++) begin
        vsel[j][c] = (cur_r.is_query && k_r == 3'(j + 1)) ? pt[c] : vs_r[j][c];
      end
    end
    for (int c = 0; c < 3; c++) begin
      u_c[c] = DIFF_W'(vsel[1][c]) - DIFF_W'(vsel[0][c]);
      v_c[c] = DIFF_W'(vsel[2][c]) - DIFF_W'(vsel[0][c]);
      w_c[c] = DIFF_W'(vsel[3][c]) - DIFF_W'(vsel[0][c]);
    end
    cof[0] = COF_W'(pr_r[0]) - COF_W'(pr_r[1]);
    cof[1] = COF_W'(pr_r[2]) - COF_W'(pr_r[3]);
    cof[2] = COF_W'(pr_r[4]) - COF_W'(pr_r[5]);
    sum_w = (DET_W+2)'(t_r[0]) - (DET_W+2)'(t_r[1]) + (DET_W+2)'(t_r[2]);
    det     = sum_w[DET_W-1:0];
    det_mag = mag(det);
    d0_mag  = mag(d0_r);
    tol_s   = DET_W'(tolerance);
    // one quotient byte per step, divisor three
    dv    = {rem_r, dvd_r[DET_W-1 -: 8]};
    dprod = 20'(dv) * 20'd683;
    q8    = dprod[18:11];
    r2    = 2'(dv - 10'(q8) * 10'd3);
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = ST_DIFF;
        end
      end
      ST_DIFF: state_nxt = ST_MUL1;
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_SUM;
      ST_SUM:  state_nxt = (cur_r.is_query && k_r != 3'd4) ? ST_DIFF : ST_PREP;
      ST_PREP: state_nxt = ST_DIV;
      ST_DIV:  state_nxt = (dcnt_r == 3'd7) ? ST_OUT : ST_DIV;
      ST_OUT:  state_nxt = out_ready ? ST_IDLE : ST_OUT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int j = 0; j < NUM_VERT; j++)
        for (int c = 0; c < 3; c++) vs_r[j][c] <= '0;
    end else begin
      state_r <= state_nxt;
      if (q_pop && !q_item.is_query) begin
        vs_r[q_item.vidx][0] <= q_item.x;
        vs_r[q_item.vidx][1] <= q_item.y;
        vs_r[q_item.vidx][2] <= q_item.z;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        cur_r    <= q_item;
        k_r      <= 3'd0;
        strict_r <= q_item.is_query;
        loose_r  <= q_item.is_query;
      end
      ST_DIFF: begin
        u_r <= u_c;
        v_r <= v_c;
        w_r <= w_c;
      end
      ST_MUL1: begin
        pr_r[0] <= v_r[1] * w_r[2];
        pr_r[1] <= v_r[2] * w_r[1];
        pr_r[2] <= v_r[0] * w_r[2];
        pr_r[3] <= v_r[2] * w_r[0];
        pr_r[4] <= v_r[0] * w_r[1];
        pr_r[5] <= v_r[1] * w_r[0];
      end
      ST_MUL2: begin
        for (int c = 0; c < 3; c++) t_r[c] <= TERM_W'(u_r[c]) * TERM_W'(cof[c]);
      end
      ST_SUM: begin
        k_r <= k_r + 3'd1;
        if (k_r == 3'd0) begin
          d0_r <= det;
        end else begin
          if (det_mag < DET_W'(tolerance) || (d0_r[DET_W-1] != det[DET_W-1]))
            strict_r <= 1'b0;
          if (d0_r[DET_W-1] ? !(det < tol_s) : !(det > -tol_s))
            loose_r <= 1'b0;
        end
      end
      ST_PREP: begin
        dvd_r  <= d0_mag >> 1;
        rem_r  <= 2'd0;
        dcnt_r <= 3'd0;
      end
      ST_DIV: begin
        dvd_r  <= dvd_r << 8;
        q_r    <= {q_r[DET_W-9:0], q8};
        rem_r  <= r2;
        dcnt_r <= dcnt_r + 3'd1;
      end
      ST_OUT: ;
      default: ;
    endcase
  end

  assign out_valid             = (state_r == ST_OUT);
  assign out_data.inside_res   = strict_r;
  assign out_data.inside_or_on = loose_r;
  assign out_data.volume       = (q_r[DET_W-1:VOL_W] != '0) ? VOL_MAX : q_r[VOL_W-1:0];

endmodule

FILE: sv/pitt_checker.sv
`include "point_in_tetrahedron_test_core_defines.svh"

module pitt_checker import pitt_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `PITT_ASSERT(a_out_hold,
    out_valid && !out_ready |=> out_valid && $stable(out_data),
    "result dropped while stalled")
  `PITT_ASSERT(a_in_hold,
    in_valid && !in_ready |=> in_valid && $stable(in_data),
    "input item changed while waiting")
  `PITT_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && in_ready, "not idle after reset")

endmodule

bind point_in_tetrahedron_test_core pitt_checker u_pitt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
